// ===== rtl/ffha_pkg.sv =====
// Shared constants, segment record and controller/datapath command types
// for the first-fit heap allocator. No dependencies.
`default_nettype none
package ffha_pkg;

  localparam int MAX_SEGMENTS = 64;
  localparam int HEADER_BYTES = 16;
  localparam int IDX_W        = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);

  localparam logic [31:0] HEAP_RESET = 32'd1048576;
  localparam logic [31:0] HDR        = 32'(HEADER_BYTES);

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NOFIT   = 2'd1;
  localparam logic [1:0] STAT_NOMATCH = 2'd2;

  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  typedef struct packed {
    logic        used;
    logic [31:0] size;
    logic [31:0] start;
  } seg_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_INIT,
    OP_LOAD,
    OP_SCAN,
    OP_DECIDE,
    OP_SHIFT,
    OP_WR_GRANT,
    OP_WR_TAIL,
    OP_NB_PREV,
    OP_NB_NEXT,
    OP_NB_CAP,
    OP_WR_MERGE,
    OP_RESP
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] code;
  } cmd_t;

  typedef struct packed {
    logic act;
    logic look;
    logic hit;
    logic last;
    logic split;
    logic shift_done;
  } stat_t;

endpackage
`default_nettype wire

// ===== rtl/ffha_dp.sv =====
// Datapath: segment table memory, scan/shift engine, merge arithmetic,
// result registers. Depends on ffha_pkg.
`default_nettype none
module ffha_dp (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [31:0]          cfg_heap_length,
  input  wire logic                 in_action,
  input  wire logic [31:0]          in_request_bytes,
  input  wire logic [31:0]          in_release_offset,
  input  wire ffha_pkg::cmd_t       cmd,
  output ffha_pkg::stat_t           stat,
  output logic [1:0]                out_status,
  output logic [31:0]               out_data_offset
);

  localparam int IW = ffha_pkg::IDX_W;
  localparam int CW = ffha_pkg::CNT_W;

  ffha_pkg::seg_t mem [ffha_pkg::MAX_SEGMENTS];

  logic [31:0]    heap_r;
  logic [CW-1:0]  cnt_r;
  logic           act_r;
  logic [31:0]    req_r, off_r;
  logic [CW-1:0]  ptr_r;
  logic           look_r;
  logic [IW-1:0]  rq_r;
  ffha_pkg::seg_t rdata_r;
  logic [IW-1:0]  idx_r;
  logic [31:0]    s_r, z_r, acc_r;
  logic           split_r;
  logic [IW-1:0]  rp_r;
  logic [CW-1:0]  left_r;
  logic           up_r;
  logic [1:0]     amt_r;
  logic           pf_r, nf_r;
  logic [IW-1:0]  tgt_idx_r;
  logic [31:0]    tgt_start_r;
  logic [1:0]     status_r;
  logic [31:0]    offset_r;

  logic           rd_en, wr_en;
  logic [IW-1:0]  rd_addr, wr_addr;
  ffha_pkg::seg_t wr_data;
  logic [CW-1:0]  idx_p1, src;
  logic           hit, split;
  logic [1:0]     amt_new;

  assign idx_p1  = CW'(idx_r) + CW'(1);
  assign src     = idx_p1 + CW'(nf_r);
  assign amt_new = 2'(pf_r) + 2'(nf_r);

  assign hit = act_r
    ? (rdata_r.used && ({1'b0, rdata_r.start} + 33'(ffha_pkg::HDR) == {1'b0, off_r}))
    : (!rdata_r.used && (rdata_r.size > req_r));
  assign split = ({1'b0, z_r} >= ({1'b0, req_r} + 33'(ffha_pkg::HDR) + 33'd1)) &&
                 (cnt_r < CW'(ffha_pkg::MAX_SEGMENTS));

  assign stat.act        = act_r;
  assign stat.look       = look_r;
  assign stat.hit        = hit;
  assign stat.last       = (CW'(rq_r) == cnt_r - CW'(1));
  assign stat.split      = split;
  assign stat.shift_done = (left_r == '0) && !look_r;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    case (cmd.op)
      ffha_pkg::OP_SCAN: begin
        rd_en   = ptr_r < cnt_r;
        rd_addr = ptr_r[IW-1:0];
      end
      ffha_pkg::OP_SHIFT: begin
        rd_en   = left_r != '0;
        rd_addr = rp_r;
        wr_en   = look_r;
        wr_addr = up_r ? rq_r + IW'(1) : rq_r - IW'(amt_r);
        wr_data = rdata_r;
      end
      ffha_pkg::OP_NB_PREV: begin
        rd_en   = 1'b1;
        rd_addr = idx_r - IW'(1);
      end
      ffha_pkg::OP_NB_NEXT: begin
        rd_en   = 1'b1;
        rd_addr = idx_r + IW'(1);  // wraps only when no next entry exists
      end
      ffha_pkg::OP_INIT: begin
        wr_en         = 1'b1;
        wr_data.used  = 1'b0;
        wr_data.start = '0;
        wr_data.size  = (heap_r > ffha_pkg::HDR) ? heap_r - ffha_pkg::HDR : '0;
      end
      ffha_pkg::OP_WR_GRANT: begin
        wr_en         = 1'b1;
        wr_addr       = idx_r;
        wr_data.used  = 1'b1;
        wr_data.start = s_r;
        wr_data.size  = split_r ? req_r : z_r;
      end
      ffha_pkg::OP_WR_TAIL: begin
        wr_en         = 1'b1;
        wr_addr       = idx_r + IW'(1);
        wr_data.used  = 1'b0;
        wr_data.start = s_r + ffha_pkg::HDR + req_r;
        wr_data.size  = z_r - req_r - ffha_pkg::HDR;
      end
      ffha_pkg::OP_WR_MERGE: begin
        wr_en         = 1'b1;
        wr_addr       = tgt_idx_r;
        wr_data.used  = 1'b0;
        wr_data.start = tgt_start_r;
        wr_data.size  = acc_r;
      end
      default: ;
    endcase
  end

  // table memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
    rq_r <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_r <= ffha_pkg::HEAP_RESET;
      cnt_r  <= CW'(1);
      look_r <= 1'b0;
      left_r <= '0;
    end else begin
      look_r <= rd_en;
      if (cfg_we) begin
        heap_r <= cfg_heap_length;
      end
      case (cmd.op)
        ffha_pkg::OP_INIT: cnt_r <= CW'(1);
        ffha_pkg::OP_LOAD: begin
          act_r <= in_action;
          req_r <= in_request_bytes;
          off_r <= in_release_offset;
          ptr_r <= '0;
        end
        ffha_pkg::OP_SCAN: begin
          if (rd_en) begin
            ptr_r <= ptr_r + CW'(1);
          end
          if (look_r && hit) begin
            idx_r       <= rq_r;
            s_r         <= rdata_r.start;
            z_r         <= rdata_r.size;
            acc_r       <= rdata_r.size;
            tgt_idx_r   <= rq_r;
            tgt_start_r <= rdata_r.start;
            pf_r        <= 1'b0;
            nf_r        <= 1'b0;
          end
        end
        ffha_pkg::OP_DECIDE: begin
          split_r <= split;
          up_r    <= 1'b1;
          amt_r   <= 2'd1;
          rp_r    <= IW'(cnt_r - CW'(1));
          left_r  <= split ? cnt_r - idx_p1 : '0;
        end
        ffha_pkg::OP_SHIFT: begin
          if (rd_en) begin
            rp_r   <= up_r ? rp_r - IW'(1) : rp_r + IW'(1);
            left_r <= left_r - CW'(1);
          end
        end
        ffha_pkg::OP_WR_TAIL: cnt_r <= cnt_r + CW'(1);
        ffha_pkg::OP_NB_NEXT: begin
          // rdata holds the entry below the released one
          if (idx_r != '0 && !rdata_r.used) begin
            pf_r        <= 1'b1;
            acc_r       <= rdata_r.size + acc_r + ffha_pkg::HDR;
            tgt_idx_r   <= idx_r - IW'(1);
            tgt_start_r <= rdata_r.start;
          end
        end
        ffha_pkg::OP_NB_CAP: begin
          if (idx_p1 < cnt_r && !rdata_r.used) begin
            nf_r  <= 1'b1;
            acc_r <= acc_r + rdata_r.size + ffha_pkg::HDR;
          end
        end
        ffha_pkg::OP_WR_MERGE: begin
          up_r   <= 1'b0;
          amt_r  <= amt_new;
          rp_r   <= src[IW-1:0];
          left_r <= (pf_r || nf_r) ? cnt_r - src : '0;
          cnt_r  <= cnt_r - CW'(amt_new);
        end
        ffha_pkg::OP_RESP: begin
          status_r <= cmd.code;
          offset_r <= (cmd.code == ffha_pkg::STAT_OK && act_r == ffha_pkg::ACT_ALLOC)
                      ? s_r + ffha_pkg::HDR : '0;
        end
        default: ;
      endcase
    end
  end

  assign out_status      = status_r;
  assign out_data_offset = offset_r;

endmodule
`default_nettype wire

// ===== rtl/ffha_ctrl.sv =====
// Controller state machine: sequences scan, split, merge and table shifts,
// owns the handshakes. Depends on ffha_pkg.
`default_nettype none
module ffha_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_we,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire ffha_pkg::stat_t stat,
  output ffha_pkg::cmd_t      cmd
);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_DECIDE = 4'd3;
  localparam logic [3:0] S_SHUP   = 4'd4;
  localparam logic [3:0] S_WRA    = 4'd5;
  localparam logic [3:0] S_WRB    = 4'd6;
  localparam logic [3:0] S_NBP    = 4'd7;
  localparam logic [3:0] S_NBN    = 4'd8;
  localparam logic [3:0] S_NBC    = 4'd9;
  localparam logic [3:0] S_WM     = 4'd10;
  localparam logic [3:0] S_SHDN   = 4'd11;
  localparam logic [3:0] S_RESP   = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic [1:0] code_r, code_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    code_nxt      = code_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = ffha_pkg::OP_NOP;
    cmd.code      = code_r;
    case (state_r)
      S_INIT: begin
        cmd.op    = ffha_pkg::OP_INIT;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = ffha_pkg::OP_LOAD;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.op = ffha_pkg::OP_SCAN;
        if (stat.look && stat.hit) begin
          code_nxt  = ffha_pkg::STAT_OK;
          state_nxt = (stat.act == ffha_pkg::ACT_RELEASE) ? S_NBP : S_DECIDE;
        end else if (stat.look && stat.last) begin
          code_nxt  = (stat.act == ffha_pkg::ACT_RELEASE) ? ffha_pkg::STAT_NOMATCH
                                                          : ffha_pkg::STAT_NOFIT;
          state_nxt = S_RESP;
        end
      end
      S_DECIDE: begin
        cmd.op    = ffha_pkg::OP_DECIDE;
        state_nxt = stat.split ? S_SHUP : S_WRA;
      end
      S_SHUP: begin
        cmd.op = ffha_pkg::OP_SHIFT;
        if (stat.shift_done) begin
          state_nxt = S_WRA;
        end
      end
      S_WRA: begin
        cmd.op    = ffha_pkg::OP_WR_GRANT;
        state_nxt = stat.split ? S_WRB : S_RESP;
      end
      S_WRB: begin
        cmd.op    = ffha_pkg::OP_WR_TAIL;
        state_nxt = S_RESP;
      end
      S_NBP: begin
        cmd.op    = ffha_pkg::OP_NB_PREV;
        state_nxt = S_NBN;
      end
      S_NBN: begin
        cmd.op    = ffha_pkg::OP_NB_NEXT;
        state_nxt = S_NBC;
      end
      S_NBC: begin
        cmd.op    = ffha_pkg::OP_NB_CAP;
        state_nxt = S_WM;
      end
      S_WM: begin
        cmd.op    = ffha_pkg::OP_WR_MERGE;
        state_nxt = S_SHDN;
      end
      S_SHDN: begin
        cmd.op = ffha_pkg::OP_SHIFT;
        if (stat.shift_done) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = ffha_pkg::OP_RESP;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
    if (cfg_we) begin
      state_nxt = S_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      code_r      <= ffha_pkg::STAT_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      code_r      <= code_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !cfg_we) |=> (!in_ready && state_r == S_SCAN))
    else $error("input beat accepted but scan not started");

  a_alloc_hit_decides: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && stat.look && stat.hit && stat.act == ffha_pkg::ACT_ALLOC
     && !cfg_we) |=> (state_r == S_DECIDE))
    else $error("allocate hit did not go to split decision");

  a_cfg_reinit: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (state_r == S_INIT))
    else $error("config write did not reinitialize table");

  a_resp_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && !cfg_we && (!out_valid_r || out_ready)) |=>
    (out_valid_r && state_r == S_IDLE))
    else $error("result beat not presented");

endmodule
`default_nettype wire

// ===== rtl/first_fit_heap_allocator.sv =====
// Top level of the first-fit heap allocator: ties controller and datapath.
// Depends on ffha_pkg, ffha_ctrl, ffha_dp.
//
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------------
//  in      | in_valid / in_ready    | in_action, in_request_bytes, in_release_offset
//  out     | out_valid / out_ready  | out_status, out_data_offset
//  cfg     | cfg_we (no wait)       | cfg_heap_length
//
// Cycles per beat: 1 (accept) + N+1 scan (N = segment count, up to 64),
// plus about M+2 for the table shift after a split or merge (M = entries
// above the hit), plus 2..4 for the split decision and split/merge writes,
// and 1 for the response.
// Set by the simple dual-port table memory: one read and one write a cycle.
// Reset and every cfg write spend one cycle rebuilding entry 0 before the
// next input beat is taken. A finished result waits in the output register;
// the next input beat is accepted while it waits, and only the following
// response stalls until out_ready.
`default_nettype none
module first_fit_heap_allocator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_heap_length,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_action,
  input  wire logic [31:0] in_request_bytes,
  input  wire logic [31:0] in_release_offset,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [31:0]      out_data_offset
);

  ffha_pkg::stat_t stat;
  ffha_pkg::cmd_t  cmd;

  // sequencer: owns all handshakes
  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // segment table, shift engine, result registers
  ffha_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_heap_length   (cfg_heap_length),
    .in_action         (in_action),
    .in_request_bytes  (in_request_bytes),
    .in_release_offset (in_release_offset),
    .cmd               (cmd),
    .stat              (stat),
    .out_status        (out_status),
    .out_data_offset   (out_data_offset)
  );

endmodule
`default_nettype wire

// ===== sim/first_fit_heap_allocator_test.sv =====
// Self-checking testbench for first_fit_heap_allocator: directed table, then
// random alloc/release traffic checked against an in-bench table predictor.
// Depends on ffha_pkg and the RTL top level.
module first_fit_heap_allocator_test;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 150;   // > scan + shift of a full table

  typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic        action;
    logic [31:0] arg;      // request, release offset or heap length
    bit          typed;    // expected result typed in below
    logic [1:0]  status;
    logic [31:0] offset;
  } row_t;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] offset;
  } grant_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_heap_length;
  logic        in_valid;
  logic        in_ready;
  logic        in_action;
  logic [31:0] in_request_bytes;
  logic [31:0] in_release_offset;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [31:0] out_data_offset;

  // Predictor copy of the segment table.
  logic [31:0] heap_len;
  logic [31:0] seg_start [ffha_pkg::MAX_SEGMENTS];
  logic [31:0] seg_size  [ffha_pkg::MAX_SEGMENTS];
  bit          seg_used  [ffha_pkg::MAX_SEGMENTS];
  int          seg_cnt;

  grant_t      grants_due[$];
  logic [31:0] live_offsets[$];    // payload offsets currently granted
  logic [31:0] freed_offsets[$];   // recently released, for double releases
  int          errors;
  int          quiet_cycles;
  int          tx_idle_pct;
  int          rx_idle_pct;

  first_fit_heap_allocator DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_heap_length   (cfg_heap_length),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_request_bytes  (in_request_bytes),
    .in_release_offset (in_release_offset),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_data_offset   (out_data_offset)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Table predictor
  // ---------------------------------------------------------------------
  function automatic void rebuild_table(logic [31:0] len);
    heap_len = len;
    for (int i = 0; i < ffha_pkg::MAX_SEGMENTS; i++) begin
      seg_start[i] = '0;
      seg_size[i]  = '0;
      seg_used[i]  = 1'b0;
    end
    seg_size[0] = (len > ffha_pkg::HDR) ? len - ffha_pkg::HDR : '0;
    seg_cnt = 1;
  endfunction

  function automatic void drop_segment(int idx);
    for (int k = idx; k + 1 < seg_cnt; k++) begin
      seg_start[k] = seg_start[k + 1];
      seg_size[k]  = seg_size[k + 1];
      seg_used[k]  = seg_used[k + 1];
    end
    seg_cnt--;
  endfunction

  // First free segment strictly larger than the request; split when the
  // tail can hold a header plus one byte and the table has room.
  function automatic grant_t carve_segment(logic [31:0] req);
    grant_t g;
    int     i;
    g.status = ffha_pkg::STAT_NOFIT;
    g.offset = '0;
    for (i = 0; i < seg_cnt; i++)
      if (!seg_used[i] && seg_size[i] > req) break;
    if (i >= seg_cnt) return g;
    if ({32'd0, seg_size[i]} >= {32'd0, req} + 64'(ffha_pkg::HDR) + 64'd1 &&
        seg_cnt < ffha_pkg::MAX_SEGMENTS) begin
      for (int k = seg_cnt; k > i + 1; k--) begin
        seg_start[k] = seg_start[k - 1];
        seg_size[k]  = seg_size[k - 1];
        seg_used[k]  = seg_used[k - 1];
      end
      seg_start[i + 1] = seg_start[i] + ffha_pkg::HDR + req;
      seg_size[i + 1]  = seg_size[i] - req - ffha_pkg::HDR;
      seg_used[i + 1]  = 1'b0;
      seg_size[i]      = req;
      seg_cnt++;
    end
    seg_used[i] = 1'b1;
    g.status = ffha_pkg::STAT_OK;
    g.offset = seg_start[i] + ffha_pkg::HDR;
    return g;
  endfunction

  // Free a used segment and coalesce with free neighbors on both sides.
  function automatic grant_t free_segment(logic [31:0] off);
    grant_t g;
    int     i;
    g.status = ffha_pkg::STAT_NOMATCH;
    g.offset = '0;
    for (i = 0; i < seg_cnt; i++)
      if (seg_used[i] && {32'd0, seg_start[i]} + 64'(ffha_pkg::HDR) == {32'd0, off}) break;
    if (i >= seg_cnt) return g;
    seg_used[i] = 1'b0;
    if (i > 0 && !seg_used[i - 1]) begin
      seg_size[i - 1] += seg_size[i] + ffha_pkg::HDR;
      drop_segment(i);
      i--;
    end
    if (i + 1 < seg_cnt && !seg_used[i + 1]) begin
      seg_size[i] += seg_size[i + 1] + ffha_pkg::HDR;
      drop_segment(i + 1);
    end
    g.status = ffha_pkg::STAT_OK;
    return g;
  endfunction

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------
  // Valid is left high after the accepting edge; the next call (or
  // park_sender) owns the following falling edge, so no double assignment.
  task automatic send_beat(logic act, logic [31:0] arg, bit typed,
                           logic [1:0] st, logic [31:0] off);
    grant_t g;
    int     gap;
    @(negedge clk);
    gap = ($urandom_range(0, 99) < tx_idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_action         <= act;
    in_request_bytes  <= (act == ffha_pkg::ACT_ALLOC) ? arg : $urandom;
    in_release_offset <= (act == ffha_pkg::ACT_RELEASE) ? arg : $urandom;
    do @(posedge clk); while (!in_ready);
    g = (act == ffha_pkg::ACT_ALLOC) ? carve_segment(arg) : free_segment(arg);
    if (typed) begin
      g.status = st;
      g.offset = off;
    end
    grants_due.push_back(g);
    if (act == ffha_pkg::ACT_ALLOC && g.status == ffha_pkg::STAT_OK)
      live_offsets.push_back(g.offset);
  endtask

  task automatic park_sender();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Sender pause: drop valid, wait for every result, let the block settle.
  task automatic drain_all();
    park_sender();
    while (grants_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_heap_length(logic [31:0] len);
    drain_all();
    cfg_we          <= 1'b1;
    cfg_heap_length <= len;
    rebuild_table(len);
    live_offsets.delete();
    freed_offsets.delete();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Receiver stalls at random.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // ---------------------------------------------------------------------
  // Result checker and watchdog
  // ---------------------------------------------------------------------
  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    grant_t g;
    if (rst_n && out_valid && out_ready) begin
      if (grants_due.size() == 0) begin
        report("unexpected beat", out_status, 0);
      end else begin
        g = grants_due.pop_front();
        if (out_status !== g.status) report("status", out_status, g.status);
        if (out_data_offset !== g.offset) report("data_offset", out_data_offset, g.offset);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  // Pick a request size scaled to the heap so the table fills and splits.
  function automatic logic [31:0] pick_request();
    if ($urandom_range(0, 19) == 0) return $urandom;   // mostly a no-fit
    if (heap_len <= 32'd4096) return $urandom_range(0, heap_len / 40);
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 32'h0400_0000);
    return $urandom_range(0, 4000);
  endfunction

  task automatic random_beat();
    int          pick;
    int          k;
    logic [31:0] off;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      // noise: arbitrary release offset
      send_beat(ffha_pkg::ACT_RELEASE, $urandom, 0, 0, 0);
    end else if (pick < 13 && freed_offsets.size() != 0) begin
      // double release
      k = $urandom_range(0, freed_offsets.size() - 1);
      send_beat(ffha_pkg::ACT_RELEASE, freed_offsets[k], 0, 0, 0);
    end else if (pick < 55 && live_offsets.size() != 0) begin
      k = $urandom_range(0, live_offsets.size() - 1);
      off = live_offsets[k];
      live_offsets.delete(k);
      freed_offsets.push_back(off);
      if (freed_offsets.size() > 16) void'(freed_offsets.pop_front());
      send_beat(ffha_pkg::ACT_RELEASE, off, 0, 0, 0);
    end else begin
      send_beat(ffha_pkg::ACT_ALLOC, pick_request(), 0, 0, 0);
    end
  endtask

  row_t        directed [$];
  logic [31:0] phase_len [6];

  initial begin
    errors            = 0;
    quiet_cycles      = 0;
    tx_idle_pct       = 0;
    rx_idle_pct       = 0;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_heap_length   = '0;
    in_valid          = 1'b0;
    in_action         = ffha_pkg::ACT_ALLOC;
    in_request_bytes  = '0;
    in_release_offset = '0;
    out_ready         = 1'b0;
    rebuild_table(ffha_pkg::HEAP_RESET);

    // Directed rows. After reset: one free segment of 1 MiB less a header.
    directed = '{
      '{ROW_ITEM, ffha_pkg::ACT_ALLOC,   32'd0,         1, ffha_pkg::STAT_OK,      32'd16},
      '{ROW_ITEM, ffha_pkg::ACT_ALLOC,   32'hFFFF_FFFF, 1, ffha_pkg::STAT_NOFIT,   32'd0},
      '{ROW_ITEM, ffha_pkg::ACT_RELEASE, 32'hFFFF_FFFF, 1, ffha_pkg::STAT_NOMATCH, 32'd0},
      '{ROW_ITEM, ffha_pkg::ACT_RELEASE, 32'd0,         1, ffha_pkg::STAT_NOMATCH, 32'd0},
      '{ROW_ITEM, ffha_pkg::ACT_ALLOC,   32'd100,       1, ffha_pkg::STAT_OK,      32'd32},
      '{ROW_ITEM, ffha_pkg::ACT_ALLOC,   32'd1048576,   1, ffha_pkg::STAT_NOFIT,   32'd0},
      '{ROW_ITEM, ffha_pkg::ACT_RELEASE, 32'd16,        1, ffha_pkg::STAT_OK,      32'd0},
      '{ROW_ITEM, ffha_pkg::ACT_RELEASE, 32'd16,        1, ffha_pkg::STAT_NOMATCH, 32'd0},
      '{ROW_ITEM, ffha_pkg::ACT_ALLOC,   32'd200,       0, 0, 0},
      '{ROW_ITEM, ffha_pkg::ACT_RELEASE, 32'd32,        0, 0, 0},
      '{ROW_ITEM, ffha_pkg::ACT_ALLOC,   32'd1048543,   0, 0, 0},
      '{ROW_ITEM, ffha_pkg::ACT_ALLOC,   32'd0,         0, 0, 0},
      // smallest usable heap: one segment of payload 1, never split
      '{ROW_CFG,  ffha_pkg::ACT_ALLOC,   32'd17,        0, 0, 0},
      '{ROW_ITEM, ffha_pkg::ACT_ALLOC,   32'd1,         1, ffha_pkg::STAT_NOFIT,   32'd0},
      '{ROW_ITEM, ffha_pkg::ACT_ALLOC,   32'd0,         1, ffha_pkg::STAT_OK,      32'd16},
      '{ROW_ITEM, ffha_pkg::ACT_ALLOC,   32'd0,         1, ffha_pkg::STAT_NOFIT,   32'd0},
      '{ROW_ITEM, ffha_pkg::ACT_RELEASE, 32'd16,        1, ffha_pkg::STAT_OK,      32'd0},
      // largest heap
      '{ROW_CFG,  ffha_pkg::ACT_ALLOC,   32'hFFFF_FFFF, 0, 0, 0},
      '{ROW_ITEM, ffha_pkg::ACT_ALLOC,   32'hFFFF_FFEE, 1, ffha_pkg::STAT_OK,      32'd16},
      '{ROW_ITEM, ffha_pkg::ACT_ALLOC,   32'd0,         1, ffha_pkg::STAT_NOFIT,   32'd0},
      '{ROW_ITEM, ffha_pkg::ACT_RELEASE, 32'd16,        1, ffha_pkg::STAT_OK,      32'd0},
      '{ROW_ITEM, ffha_pkg::ACT_ALLOC,   32'hFFFF_FFEC, 0, 0, 0},
      '{ROW_ITEM, ffha_pkg::ACT_ALLOC,   32'd0,         0, 0, 0}
    };

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    repeat (4) @(negedge clk);   // entry 0 rebuild after reset

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG)
        write_heap_length(directed[i].arg);
      else
        send_beat(directed[i].action, directed[i].arg, directed[i].typed,
                  directed[i].status, directed[i].offset);
    end

    // Random phases; a small heap fills the 64-entry table quickly.
    phase_len = '{32'd4096, ffha_pkg::HEAP_RESET, 32'hFFFF_FFFF, 32'd17, 32'd300,
                  32'd2048};
    for (int n = 0; n < 2000; n++) begin
      if (n % 334 == 0)
        write_heap_length(phase_len[n / 334]);
      // sender 29 / receiver 83, then swapped, then no idling
      if (n < 667) begin
        tx_idle_pct = 29;
        rx_idle_pct = 83;
      end else if (n < 1334) begin
        tx_idle_pct = 83;
        rx_idle_pct = 29;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      random_beat();
    end

    park_sender();
    while (grants_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ffha_pkg.sv
rtl/ffha_dp.sv
rtl/ffha_ctrl.sv
rtl/first_fit_heap_allocator.sv
sim/first_fit_heap_allocator_test.sv
